// ----- rtl/rgbseq_pkg.sv -----
// Shared types, defaults and the pattern ROM of the RGB LED pattern sequencer.
// No dependencies; used by rgbseq_step and rgb_led_pattern_sequencer_core.
package rgbseq_pkg;

  localparam int unsigned PatternTotalDef = 15;
  localparam int unsigned FramesMaxDef    = 4;

  localparam int unsigned TimeW  = 10;
  localparam int unsigned RepsW  = 2;
  localparam int unsigned FrameW = 2;
  localparam int unsigned PatW   = 4;
  localparam int unsigned CountW = 3;

  typedef struct packed {
    logic [TimeW-1:0] on_r;
    logic [TimeW-1:0] on_g;
    logic [TimeW-1:0] on_b;
    logic [TimeW-1:0] period;
    logic [RepsW-1:0] reps;
  } frame_t;

  typedef struct packed {
    logic [FrameW-1:0] frame_pos;
    logic [RepsW-1:0]  reps_left;
    logic [TimeW-1:0]  elapsed;
  } seq_state_t;

  typedef struct packed {
    logic              red;
    logic              green;
    logic              blue;
    logic [FrameW-1:0] frame;
  } led_word_t;

  // Frame table: 16 rows of 4 frames, unused slots are all zero.
  function automatic frame_t frame_rom(input logic [PatW-1:0] row,
                                       input logic [FrameW-1:0] col);
    frame_t f;
    f = '0;
    case ({row, col})
      {4'd0,  2'd0}: f = '{10'd0,    10'd0,    10'd0,    10'd1000, 2'd0};
      {4'd1,  2'd0}: f = '{10'd1000, 10'd0,    10'd0,    10'd1000, 2'd0};
      {4'd2,  2'd0}: f = '{10'd0,    10'd1000, 10'd0,    10'd1000, 2'd0};
      {4'd3,  2'd0}: f = '{10'd0,    10'd0,    10'd1000, 10'd1000, 2'd0};
      {4'd4,  2'd0}: f = '{10'd1000, 10'd1000, 10'd0,    10'd1000, 2'd0};
      {4'd5,  2'd0}: f = '{10'd0,    10'd1000, 10'd1000, 10'd1000, 2'd0};
      {4'd6,  2'd0}: f = '{10'd1000, 10'd0,    10'd1000, 10'd1000, 2'd0};
      {4'd7,  2'd0}: f = '{10'd1000, 10'd1000, 10'd1000, 10'd1000, 2'd0};
      {4'd8,  2'd0}: f = '{10'd100,  10'd0,    10'd0,    10'd300,  2'd2};
      {4'd8,  2'd1}: f = '{10'd0,    10'd0,    10'd0,    10'd300,  2'd2};
      {4'd9,  2'd0}: f = '{10'd0,    10'd100,  10'd0,    10'd300,  2'd2};
      {4'd9,  2'd1}: f = '{10'd0,    10'd0,    10'd0,    10'd300,  2'd2};
      {4'd10, 2'd0}: f = '{10'd0,    10'd0,    10'd100,  10'd300,  2'd2};
      {4'd10, 2'd1}: f = '{10'd0,    10'd0,    10'd0,    10'd300,  2'd2};
      {4'd11, 2'd0}: f = '{10'd180,  10'd70,   10'd0,    10'd400,  2'd3};
      {4'd11, 2'd1}: f = '{10'd0,    10'd0,    10'd0,    10'd400,  2'd1};
      {4'd12, 2'd0}: f = '{10'd0,    10'd180,  10'd180,  10'd400,  2'd3};
      {4'd12, 2'd1}: f = '{10'd0,    10'd0,    10'd0,    10'd400,  2'd1};
      {4'd13, 2'd0}: f = '{10'd800,  10'd0,    10'd0,    10'd250,  2'd1};
      {4'd13, 2'd1}: f = '{10'd0,    10'd800,  10'd0,    10'd250,  2'd1};
      {4'd13, 2'd2}: f = '{10'd0,    10'd0,    10'd800,  10'd250,  2'd1};
      {4'd14, 2'd0}: f = '{10'd160,  10'd0,    10'd0,    10'd240,  2'd1};
      {4'd14, 2'd1}: f = '{10'd0,    10'd0,    10'd0,    10'd120,  2'd1};
      {4'd14, 2'd2}: f = '{10'd160,  10'd0,    10'd0,    10'd240,  2'd1};
      {4'd14, 2'd3}: f = '{10'd0,    10'd0,    10'd0,    10'd700,  2'd1};
      default:       f = '0;
    endcase
    return f;
  endfunction

  // Number of frames stored in each row.
  function automatic logic [CountW-1:0] frames_stored(input logic [PatW-1:0] row);
    logic [CountW-1:0] n;
    case (row)
      4'd0, 4'd1, 4'd2, 4'd3,
      4'd4, 4'd5, 4'd6, 4'd7:         n = 3'd1;
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12: n = 3'd2;
      4'd13:                          n = 3'd3;
      4'd14:                          n = 3'd4;
      default:                        n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/rgbseq_step.sv -----
// One millisecond step of the sequencer: next frame/repeat/elapsed state and LED enables.
// Depends on rgbseq_pkg (frame ROM, state and result types).
module rgbseq_step #(
  parameter int unsigned FramesMax = rgbseq_pkg::FramesMaxDef
) (
  input  logic [rgbseq_pkg::PatW-1:0] pattern_i,
  input  rgbseq_pkg::seq_state_t      state_i,
  input  logic                        advance_i,
  output rgbseq_pkg::seq_state_t      state_o,
  output rgbseq_pkg::led_word_t       leds_o
);

  rgbseq_pkg::frame_t                   cur_frame;
  rgbseq_pkg::frame_t                   nxt_frame;
  rgbseq_pkg::frame_t                   out_frame;
  logic [rgbseq_pkg::CountW-1:0]        row_count;
  logic [rgbseq_pkg::CountW-1:0]        total;
  logic [rgbseq_pkg::CountW-1:0]        pos_inc;
  logic [rgbseq_pkg::FrameW-1:0]        next_pos;
  logic [rgbseq_pkg::TimeW-1:0]         elapsed_inc;

  always_comb begin
    row_count = rgbseq_pkg::frames_stored(pattern_i);
    // clamp to the frame limit; an empty row plays as one static frame
    total = row_count;
    if (total > rgbseq_pkg::CountW'(FramesMax)) begin
      total = rgbseq_pkg::CountW'(FramesMax);
    end
    if (total == '0) begin
      total = rgbseq_pkg::CountW'(1);
    end
    pos_inc  = {1'b0, state_i.frame_pos} + rgbseq_pkg::CountW'(1);
    next_pos = (pos_inc < total) ? pos_inc[rgbseq_pkg::FrameW-1:0] : '0;
  end

  always_comb begin
    cur_frame   = rgbseq_pkg::frame_rom(pattern_i, state_i.frame_pos);
    nxt_frame   = rgbseq_pkg::frame_rom(pattern_i, next_pos);
    elapsed_inc = state_i.elapsed + rgbseq_pkg::TimeW'(1);
    state_o     = state_i;
    if (advance_i && (cur_frame.reps != '0)) begin
      state_o.elapsed = elapsed_inc;
      if (elapsed_inc >= cur_frame.period) begin
        state_o.elapsed = '0;
        if (state_i.reps_left > rgbseq_pkg::RepsW'(1)) begin
          state_o.reps_left = state_i.reps_left - rgbseq_pkg::RepsW'(1);
        end else begin
          state_o.frame_pos = next_pos;
          state_o.reps_left = nxt_frame.reps;
        end
      end
    end
  end

  // A static frame always sits at elapsed zero, so "below on-time" also covers
  // the "on-time nonzero" rule there.
  always_comb begin
    out_frame    = rgbseq_pkg::frame_rom(pattern_i, state_o.frame_pos);
    leds_o.red   = state_o.elapsed < out_frame.on_r;
    leds_o.green = state_o.elapsed < out_frame.on_g;
    leds_o.blue  = state_o.elapsed < out_frame.on_b;
    leds_o.frame = state_o.frame_pos;
  end

endmodule

// ----- rtl/rgb_led_pattern_sequencer_core.sv -----
// RGB LED pattern sequencer: tick input register, step logic, result register.
// Depends on rgbseq_pkg and rgbseq_step.
//
// Each input word is one millisecond tick (advance = 1) or a status query
// (advance = 0); each gives exactly one result word with the red, green and
// blue enables and the frame now playing, as seen after that tick. The block
// takes one word per clock while the output is not stalled; a word passes an
// input register and then the result register on its way to the output. While
// a result waits on a stalled output, one more word can sit in the input
// register before the input stalls. Writing pattern_select restarts the chosen
// pattern at frame zero; values at or above PatternTotal are dropped. Write it
// only while no word is in flight.
module rgb_led_pattern_sequencer_core #(
  parameter int unsigned PatternTotal = rgbseq_pkg::PatternTotalDef,
  parameter int unsigned FramesMax    = rgbseq_pkg::FramesMaxDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pattern_select_we_i,
  input  logic [rgbseq_pkg::PatW-1:0]   pattern_select_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          advance_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          red_on_o,
  output logic                          green_on_o,
  output logic                          blue_on_o,
  output logic [rgbseq_pkg::FrameW-1:0] current_frame_o
);

  logic [rgbseq_pkg::PatW-1:0] pattern_q;
  rgbseq_pkg::seq_state_t      state_q;
  rgbseq_pkg::seq_state_t      state_d;
  rgbseq_pkg::led_word_t       leds_d;
  rgbseq_pkg::led_word_t       leds_q;
  logic                        tick_valid_q;
  logic                        tick_adv_q;
  logic                        out_valid_q;
  logic                        step_go;
  logic                        in_take;
  logic                        pat_ok;

  assign step_go    = tick_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = tick_valid_q && !step_go;
  assign in_take    = in_valid_i && !in_stall_o;
  assign pat_ok     = ({1'b0, pattern_select_i} < (rgbseq_pkg::PatW+1)'(PatternTotal));

  rgbseq_step #(
    .FramesMax(FramesMax)
  ) u_step (
    .pattern_i (pattern_q),
    .state_i   (state_q),
    .advance_i (tick_adv_q),
    .state_o   (state_d),
    .leds_o    (leds_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q          <= '0;
      state_q.frame_pos  <= '0;
      state_q.elapsed    <= '0;
      state_q.reps_left  <= rgbseq_pkg::frame_rom('0, '0).reps;
      tick_valid_q       <= 1'b0;
      out_valid_q        <= 1'b0;
    end else begin
      if (pattern_select_we_i && pat_ok) begin
        // restart the new pattern at its first frame
        pattern_q         <= pattern_select_i;
        state_q.frame_pos <= '0;
        state_q.elapsed   <= '0;
        state_q.reps_left <= rgbseq_pkg::frame_rom(pattern_select_i, '0).reps;
      end else if (step_go) begin
        state_q <= state_d;
      end
      if (in_take) begin
        tick_valid_q <= 1'b1;
      end else if (step_go) begin
        tick_valid_q <= 1'b0;
      end
      if (step_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tick_adv_q <= advance_i;
    end
    if (step_go) begin
      leds_q <= leds_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_on_o        = leds_q.red;
  assign green_on_o      = leds_q.green;
  assign blue_on_o       = leds_q.blue;
  assign current_frame_o = leds_q.frame;

endmodule
